// ===== hw/rtl/m7tag_pkg.sv =====
package m7tag_pkg;

  // Largest magnitude of a 16.16 result
  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;

  // Divider geometry
  localparam int DIV_STEPS = 32;
  localparam int NUM_W     = 49;
  localparam int DEN_W     = 33;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_COS     = 3'd0,
    REG_SIN     = 3'd1,
    REG_CAM_X   = 3'd2,
    REG_CAM_Y   = 3'd3,
    REG_HEIGHT  = 3'd4,
    REG_SCALE_H = 3'd5,
    REG_SCALE_V = 3'd6,
    REG_HORIZON = 3'd7
  } cfg_reg_t;

  // 16.16 multiply: round half away from zero, saturate to +-SAT_MAX
  function automatic logic signed [31:0] fx_mul(input logic signed [32:0] a,
                                                input logic signed [32:0] b);
    logic        neg;
    logic [32:0] ma;
    logic [32:0] mb;
    logic [63:0] prod;
    logic [47:0] q;
    logic [31:0] qs;
    neg  = a[32] ^ b[32];
    ma   = a[32] ? 33'(-a) : 33'(a);
    mb   = b[32] ? 33'(-b) : 33'(b);
    prod = ma[31:0] * mb[31:0];
    q    = 48'((prod + 64'h8000) >> 16);
    qs   = (q > 48'(SAT_MAX)) ? SAT_MAX : q[31:0];
    return neg ? $signed(-qs) : $signed(qs);
  endfunction

endpackage

// ===== hw/rtl/m7tag_div.sv =====
// Pipelined 16.16 divide, one quotient bit per stage, rounded half away
// from zero, saturating with a flag. Stages advance only while en is high.
module m7tag_div #(
  parameter int SIDE_W = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [31:0]  a,
  input  logic signed [31:0]  b,
  input  logic [SIDE_W-1:0]   side_in,
  output logic                out_valid,
  output logic signed [31:0]  q,
  output logic                flag,
  output logic [SIDE_W-1:0]   side_out
);

  localparam int S  = m7tag_pkg::DIV_STEPS;
  localparam int NW = m7tag_pkg::NUM_W;
  localparam int DW = m7tag_pkg::DEN_W;

  logic              v_r    [0:S];
  logic [NW-1:0]     num_r  [0:S];
  logic [DW-1:0]     den_r  [0:S];
  logic [DW-1:0]     rem_r  [0:S];
  logic [31:0]       quo_r  [0:S];
  logic              ovf_r  [0:S];
  logic              zero_r [0:S];
  logic              neg_r  [0:S];
  logic              aneg_r [0:S];
  logic [SIDE_W-1:0] side_r [0:S];

  logic [DW-1:0] rem_nxt [1:S];
  logic [31:0]   quo_nxt [1:S];

  // Prep: magnitudes, rounding term, overflow check
  logic [31:0]   ma;
  logic [DW-1:0] md;
  logic [NW-1:0] num_nxt;
  always_comb begin
    ma      = a[31] ? 32'(-a) : 32'(a);
    md      = b[31] ? DW'(-(33'(b))) : DW'(b);
    num_nxt = NW'({ma, 17'h0}) + NW'(md);
  end

  // One restoring step per stage
  always_comb begin
    for (int k = 1; k <= S; k++) begin
      logic [DW:0] t;
      logic        ge;
      t  = {rem_r[k-1], num_r[k-1][S-k]};
      ge = t >= {1'b0, den_r[k-1]};
      rem_nxt[k] = ge ? DW'(t - {1'b0, den_r[k-1]}) : DW'(t);
      quo_nxt[k] = {quo_r[k-1][30:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= S; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 1; k <= S; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r[0]  <= num_nxt;
      den_r[0]  <= DW'({md, 1'b0});
      rem_r[0]  <= DW'(num_nxt[NW-1:32]);
      quo_r[0]  <= '0;
      ovf_r[0]  <= DW'(num_nxt[NW-1:32]) >= DW'({md, 1'b0});
      zero_r[0] <= (b == 32'sd0);
      neg_r[0]  <= a[31] ^ b[31];
      aneg_r[0] <= a[31];
      side_r[0] <= side_in;
      for (int k = 1; k <= S; k++) begin
        num_r[k]  <= num_r[k-1];
        den_r[k]  <= den_r[k-1];
        rem_r[k]  <= rem_nxt[k];
        quo_r[k]  <= quo_nxt[k];
        ovf_r[k]  <= ovf_r[k-1];
        zero_r[k] <= zero_r[k-1];
        neg_r[k]  <= neg_r[k-1];
        aneg_r[k] <= aneg_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Final: saturation and sign
  logic              ov_r;
  logic signed [31:0] q_r;
  logic              flag_r;
  logic [SIDE_W-1:0] side_o_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= v_r[S];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      side_o_r <= side_r[S];
      if (zero_r[S]) begin
        q_r    <= aneg_r[S] ? $signed(-m7tag_pkg::SAT_MAX) : $signed(m7tag_pkg::SAT_MAX);
        flag_r <= 1'b1;
      end else if (ovf_r[S] || quo_r[S][31]) begin
        q_r    <= neg_r[S] ? $signed(-m7tag_pkg::SAT_MAX) : $signed(m7tag_pkg::SAT_MAX);
        flag_r <= 1'b1;
      end else begin
        q_r    <= neg_r[S] ? $signed(-quo_r[S]) : $signed(quo_r[S]);
        flag_r <= 1'b0;
      end
    end
  end

  assign out_valid = ov_r;
  assign q         = q_r;
  assign flag      = flag_r;
  assign side_out  = side_o_r;

endmodule

// ===== hw/rtl/mode7_texel_address_generator.sv =====
// Mode 7 texel address generator: one pixel (column, row) in, one wrapped
// tile texel (x, y) plus a division-saturation flag out. Fully pipelined:
// a new pixel may be transferred every clock while in_ready is high. The
// path runs through the two 34-stage bit-per-stage dividers (line distance,
// then step). The whole pipeline advances together and freezes while the output waits.
// Registers are written through cfg_we/cfg_index/cfg_wdata and must only
// change while no pixel is in flight.
module mode7_texel_address_generator #(
  parameter int SCREEN_WIDTH     = 320,
  parameter int TILE_WIDTH_LOG2  = 6,
  parameter int TILE_HEIGHT_LOG2 = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [8:0]  in_pixel_col,
  input  logic [7:0]  in_pixel_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_texel_x,
  output logic [5:0]  out_texel_y,
  output logic        out_div_saturated
);

  localparam logic signed [12:0] HALF_W = 13'(SCREEN_WIDTH / 2);
  localparam logic [5:0] MASK_X = (TILE_WIDTH_LOG2 >= 6) ? 6'h3F :
                                  6'((1 << TILE_WIDTH_LOG2) - 1);
  localparam logic [5:0] MASK_Y = (TILE_HEIGHT_LOG2 >= 6) ? 6'h3F :
                                  6'((1 << TILE_HEIGHT_LOG2) - 1);

  // Configuration registers
  logic signed [17:0] cos_r, sin_r;
  logic signed [31:0] cam_x_r, cam_y_r, height_r, scale_h_r, scale_v_r;
  logic signed [15:0] horizon_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r     <= 18'sd65536;
      sin_r     <= '0;
      cam_x_r   <= '0;
      cam_y_r   <= '0;
      height_r  <= 32'sd3276800;
      scale_h_r <= 32'sd13107200;
      scale_v_r <= 32'sd13107200;
      horizon_r <= 16'sd20;
    end else if (cfg_we) begin
      case (m7tag_pkg::cfg_reg_t'(cfg_index))
        m7tag_pkg::REG_COS:     cos_r     <= cfg_wdata[17:0];
        m7tag_pkg::REG_SIN:     sin_r     <= cfg_wdata[17:0];
        m7tag_pkg::REG_CAM_X:   cam_x_r   <= cfg_wdata;
        m7tag_pkg::REG_CAM_Y:   cam_y_r   <= cfg_wdata;
        m7tag_pkg::REG_HEIGHT:  height_r  <= cfg_wdata;
        m7tag_pkg::REG_SCALE_H: scale_h_r <= cfg_wdata;
        m7tag_pkg::REG_SCALE_V: scale_v_r <= cfg_wdata;
        m7tag_pkg::REG_HORIZON: horizon_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Global advance: move when the output slot is free or being taken
  logic en;
  logic out_v_r;
  assign en       = !out_v_r || out_ready;
  assign in_ready = en;

  // Stage 0: input register
  logic       s0_v_r;
  logic [8:0] s0_col_r;
  logic [7:0] s0_row_r;
  // Stage 1: height*scale_v and row divisor
  logic              s1_v_r;
  logic [8:0]        s1_col_r;
  logic signed [31:0] s1_prod_r;
  logic signed [31:0] s1_dvs_r;
  logic [15:0]       row_sum;
  assign row_sum = 16'(s0_row_r) + horizon_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_valid;
      s1_v_r <= s0_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s0_col_r  <= in_pixel_col;
      s0_row_r  <= in_pixel_row;
      s1_col_r  <= s0_col_r;
      s1_prod_r <= m7tag_pkg::fx_mul(33'(height_r), 33'(scale_v_r));
      s1_dvs_r  <= {row_sum, 16'h0};
    end
  end

  // Line distance
  logic              d1_v;
  logic signed [31:0] line_dist;
  logic              d1_flag;
  logic [8:0]        d1_col;
  m7tag_div #(.SIDE_W(9)) u_div_dist (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s1_v_r), .a(s1_prod_r), .b(s1_dvs_r), .side_in(s1_col_r),
    .out_valid(d1_v), .q(line_dist), .flag(d1_flag), .side_out(d1_col)
  );

  // Step per column
  logic              d2_v;
  logic signed [31:0] hscale;
  logic              d2_flag;
  logic [41:0]       d2_side;
  m7tag_div #(.SIDE_W(42)) u_div_step (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(d1_v), .a(line_dist), .b(scale_h_r),
    .side_in({d1_flag, line_dist, d1_col}),
    .out_valid(d2_v), .q(hscale), .flag(d2_flag), .side_out(d2_side)
  );

  // Stage A: rotate step and line start offset
  logic              sa_v_r, sa_flag_r;
  logic [8:0]        sa_col_r;
  logic signed [31:0] sa_ldx_r, sa_ldy_r, sa_dx_r, sa_dy_r;
  logic signed [31:0] d2_dist;
  assign d2_dist = d2_side[40:9];
  // Stage B: plane point
  logic              sb_v_r, sb_flag_r;
  logic [31:0]       sb_px_r, sb_py_r;
  logic signed [12:0] col_off;
  assign col_off = $signed({4'b0, sa_col_r}) - HALF_W;
  // Output register
  logic [31:0] px_rnd, py_rnd;
  assign px_rnd = sb_px_r + 32'h8000;
  assign py_rnd = sb_py_r + 32'h8000;
  logic [5:0] tx_r, ty_r;
  logic       sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_v_r  <= 1'b0;
      sb_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      sa_v_r  <= d2_v;
      sb_v_r  <= sa_v_r;
      out_v_r <= sb_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sa_col_r  <= d2_side[8:0];
      sa_flag_r <= d2_side[41] | d2_flag;
      sa_ldx_r  <= m7tag_pkg::fx_mul(-(33'(sin_r)), 33'(hscale));
      sa_ldy_r  <= m7tag_pkg::fx_mul(33'(cos_r), 33'(hscale));
      sa_dx_r   <= m7tag_pkg::fx_mul(33'(d2_dist), 33'(cos_r));
      sa_dy_r   <= m7tag_pkg::fx_mul(33'(d2_dist), 33'(sin_r));
      sb_flag_r <= sa_flag_r;
      sb_px_r   <= 32'(cam_x_r) + 32'(sa_dx_r) + 32'(45'(col_off) * 45'(sa_ldx_r));
      sb_py_r   <= 32'(cam_y_r) + 32'(sa_dy_r) + 32'(45'(col_off) * 45'(sa_ldy_r));
      tx_r      <= px_rnd[21:16] & MASK_X;
      ty_r      <= py_rnd[21:16] & MASK_Y;
      sat_r     <= sb_flag_r;
    end
  end

  assign out_valid         = out_v_r;
  assign out_texel_x       = tx_r;
  assign out_texel_y       = ty_r;
  assign out_div_saturated = sat_r;

  // Checks
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_v_r && !s0_v_r)
    else $error("pipeline valid not cleared by reset");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (sa_v_r && !en) |=> sa_v_r && $stable(sa_ldx_r))
    else $error("stage lost an item during a stall");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ready) |=> out_v_r && $stable({tx_r, ty_r, sat_r}))
    else $error("result changed while waiting for transfer");

endmodule

// ===== test/tb_top.sv =====
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIXELS_PER_LINE = 320;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 10;
  localparam int RAND_ITEMS  = 190;
  localparam int HOLD_AT     = 700;
  localparam int HOLD_CYCLES = 300;
  localparam logic [63:0] FX_MAX = 64'h7FFF_FFFF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [8:0]  in_pixel_col = '0;
  logic [7:0]  in_pixel_row = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  out_texel_x;
  logic [5:0]  out_texel_y;
  logic        out_div_saturated;

  mode7_texel_address_generator DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_pixel_col(in_pixel_col), .in_pixel_row(in_pixel_row),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_texel_x(out_texel_x), .out_texel_y(out_texel_y),
    .out_div_saturated(out_div_saturated)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic [5:0] tx;
    logic [5:0] ty;
    logic       sat;
  } texel_t;

  typedef struct packed {
    logic [3:0]  ph;
    logic [8:0]  col;
    logic [7:0]  row;
    logic        known;
    texel_t      res;
  } dir_row_t;

  // Register mirror, already masked to each register's width
  logic [31:0] cfg_mirror [8];
  texel_t      texel_q [$];
  int          errors = 0;
  int          results_seen = 0;
  bit          calm = 1'b0;
  bit          stim_done = 1'b0;

  // Directed rows: phase, column, row, known, expected texel
  localparam int DIR_N = 22;
  dir_row_t dir_tab [DIR_N] = '{
    '{4'd0, 9'd0,   8'd0,   1'b0, '0},
    '{4'd0, 9'd319, 8'd255, 1'b0, '0},
    '{4'd0, 9'd511, 8'd255, 1'b0, '0},
    '{4'd0, 9'd0,   8'd255, 1'b0, '0},
    '{4'd0, 9'd319, 8'd0,   1'b0, '0},
    '{4'd0, 9'd160, 8'd128, 1'b0, '0},
    '{4'd0, 9'd256, 8'd1,   1'b0, '0},
    '{4'd0, 9'd170, 8'd85,  1'b0, '0},
    '{4'd1, 9'd0,   8'd0,   1'b1, '{6'd0, 6'd0, 1'b0}},
    '{4'd1, 9'd319, 8'd255, 1'b1, '{6'd0, 6'd0, 1'b0}},
    '{4'd1, 9'd511, 8'd100, 1'b1, '{6'd0, 6'd0, 1'b0}},
    '{4'd2, 9'd100, 8'd5,   1'b0, '0},
    '{4'd2, 9'd100, 8'd4,   1'b0, '0},
    '{4'd2, 9'd100, 8'd6,   1'b0, '0},
    '{4'd2, 9'd0,   8'd0,   1'b0, '0},
    '{4'd3, 9'd0,   8'd0,   1'b0, '0},
    '{4'd3, 9'd319, 8'd255, 1'b0, '0},
    '{4'd3, 9'd511, 8'd1,   1'b0, '0},
    '{4'd4, 9'd0,   8'd0,   1'b0, '0},
    '{4'd4, 9'd319, 8'd255, 1'b0, '0},
    '{4'd4, 9'd160, 8'd128, 1'b0, '0},
    '{4'd4, 9'd511, 8'd255, 1'b0, '0}
  };

  // 16.16 multiply, round half away from zero, saturating magnitude
  function automatic logic signed [63:0] fx_product(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] q;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    q  = (ma * mb + 64'h8000) >> 16;
    if (q > FX_MAX) q = FX_MAX;
    return ((a < 0) != (b < 0)) ? -$signed(q) : $signed(q);
  endfunction

  // 16.16 divide with saturation; zero divisor saturates by dividend sign
  function automatic logic signed [63:0] fx_quotient(input logic signed [63:0] a,
                                                     input logic signed [63:0] b,
                                                     output logic ovf);
    logic [63:0] n;
    logic [63:0] d;
    logic [63:0] q;
    ovf = 1'b0;
    if (b == 0) begin
      ovf = 1'b1;
      return (a < 0) ? -$signed(FX_MAX) : $signed(FX_MAX);
    end
    n = ((a < 0) ? -a : a) << 16;
    d = (b < 0) ? -b : b;
    q = (2 * n + d) / (2 * d);
    if (q > FX_MAX) begin
      ovf = 1'b1;
      q   = FX_MAX;
    end
    return ((a < 0) != (b < 0)) ? -$signed(q) : $signed(q);
  endfunction

  // Floor-plane texel for one pixel under the mirrored registers
  function automatic texel_t floor_texel(input logic [8:0] col, input logic [7:0] row);
    logic signed [63:0] c, s, cx, cy, h, shz, svt, hor, sum, dv;
    logic signed [63:0] line_dist, hscale, ldx, ldy, fwd_x, fwd_y;
    logic        f1, f2;
    logic [31:0] px, py;
    texel_t      r;
    c   = $signed(cfg_mirror[m7tag_pkg::REG_COS][17:0]);
    s   = $signed(cfg_mirror[m7tag_pkg::REG_SIN][17:0]);
    cx  = $signed(cfg_mirror[m7tag_pkg::REG_CAM_X]);
    cy  = $signed(cfg_mirror[m7tag_pkg::REG_CAM_Y]);
    h   = $signed(cfg_mirror[m7tag_pkg::REG_HEIGHT]);
    shz = $signed(cfg_mirror[m7tag_pkg::REG_SCALE_H]);
    svt = $signed(cfg_mirror[m7tag_pkg::REG_SCALE_V]);
    hor = $signed(cfg_mirror[m7tag_pkg::REG_HORIZON][15:0]);
    // row sum wraps to 16 bits, so the divisor may hit zero or flip sign
    sum       = $signed({56'd0, row}) + hor;
    dv        = $signed({sum[15:0], 16'd0});
    line_dist = fx_quotient(fx_product(h, svt), dv, f1);
    hscale    = fx_quotient(line_dist, shz, f2);
    ldx       = fx_product(-s, hscale);
    ldy       = fx_product(c, hscale);
    fwd_x     = fx_product(line_dist, c);
    fwd_y     = fx_product(line_dist, s);
    px = cx[31:0] + fwd_x[31:0] - 32'(PIXELS_PER_LINE / 2) * ldx[31:0]
       + {23'd0, col} * ldx[31:0] + 32'h8000;
    py = cy[31:0] + fwd_y[31:0] - 32'(PIXELS_PER_LINE / 2) * ldy[31:0]
       + {23'd0, col} * ldy[31:0] + 32'h8000;
    r.tx  = px[21:16];
    r.ty  = py[21:16];
    r.sat = f1 | f2;
    return r;
  endfunction

  // One register write per clock; caller lowers cfg_we afterwards
  task automatic write_reg(input m7tag_pkg::cfg_reg_t idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      m7tag_pkg::REG_COS, m7tag_pkg::REG_SIN: cfg_mirror[idx] = {14'd0, val[17:0]};
      m7tag_pkg::REG_HORIZON:                 cfg_mirror[idx] = {16'd0, val[15:0]};
      default:                                cfg_mirror[idx] = val;
    endcase
  endtask

  task automatic load_camera(input int c, input int s, input int cx, input int cy,
                             input int h, input int sh, input int sv, input int hor);
    write_reg(m7tag_pkg::REG_COS, c);
    write_reg(m7tag_pkg::REG_SIN, s);
    write_reg(m7tag_pkg::REG_CAM_X, cx);
    write_reg(m7tag_pkg::REG_CAM_Y, cy);
    write_reg(m7tag_pkg::REG_HEIGHT, h);
    write_reg(m7tag_pkg::REG_SCALE_H, sh);
    write_reg(m7tag_pkg::REG_SCALE_V, sv);
    write_reg(m7tag_pkg::REG_HORIZON, hor);
    cfg_we <= 1'b0;
  endtask

  // Wait until every expected texel has come back
  task automatic drain();
    while (texel_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Offer one pixel and hold it until the transfer
  task automatic send_pixel(input logic [8:0] col, input logic [7:0] row);
    int gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_pixel_col <= col;
    in_pixel_row <= row;
    do @(posedge clk); while (!in_ready);
    texel_q.push_back(floor_texel(col, row));
  endtask

  task automatic directed_camera(input int ph);
    case (ph)
      0: ;
      1: load_camera(65536, 0, 0, 0, 0, 13107200, 13107200, 20);
      2: load_camera(46341, 46341, 12345678, -9876543, 3276800, 13107200, 655360, -5);
      3: load_camera(-65536, 65536, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0,
                     32'h8000_0000, 32767);
      default: load_camera(65536, -65536, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                           32'h8000_0000, 32'h7FFF_FFFF, -32768);
    endcase
  endtask

  task automatic random_camera();
    int c, s, h, sh, sv, hor;
    c = int'($urandom_range(0, 131072)) - 65536;
    s = int'($urandom_range(0, 131072)) - 65536;
    if ($urandom_range(0, 9) < 7) begin
      // plausible floor view
      h   = int'($urandom_range(1, 400) << 16) + int'($urandom_range(0, 65535));
      sh  = int'($urandom_range(1, 1024) << 16) + int'($urandom_range(0, 65535));
      sv  = int'($urandom_range(1, 1024) << 16) + int'($urandom_range(0, 65535));
      hor = int'($urandom_range(0, 130)) - 10;
      if ($urandom_range(0, 3) == 0) h = -h;
    end else begin
      h   = $urandom;
      sh  = $urandom;
      sv  = $urandom;
      hor = int'($urandom_range(0, 65535)) - 32768;
    end
    load_camera(c, s, $urandom, $urandom, h, sh, sv, hor);
  endtask

  // Result side: random stalls, one long hold-off, compare to oldest expectation
  initial begin : result_side
    int     gap;
    bit     held;
    texel_t exp_t;
    held = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 4);
      if (!held && results_seen == HOLD_AT) begin
        gap  = HOLD_CYCLES;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_seen++;
      if (texel_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer x=%0d y=%0d sat=%0b", $time,
                 out_texel_x, out_texel_y, out_div_saturated);
      end else begin
        exp_t = texel_q.pop_front();
        if (out_texel_x !== exp_t.tx) begin
          errors++;
          $display("%0t: texel_x expected %0d actual %0d", $time, exp_t.tx, out_texel_x);
        end
        if (out_texel_y !== exp_t.ty) begin
          errors++;
          $display("%0t: texel_y expected %0d actual %0d", $time, exp_t.ty, out_texel_y);
        end
        if (out_div_saturated !== exp_t.sat) begin
          errors++;
          $display("%0t: div_saturated expected %0b actual %0b", $time, exp_t.sat,
                   out_div_saturated);
        end
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    int cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    int  cur_ph;
    bit  bad;
    cur_ph = 0;
    cfg_mirror = '{32'd65536, 32'd0, 32'd0, 32'd0, 32'd3276800, 32'd13107200,
                   32'd13107200, 32'd20};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows; known rows also checked against the typed-in texel
    for (int i = 0; i < DIR_N; i++) begin
      if (int'(dir_tab[i].ph) != cur_ph) begin
        in_valid <= 1'b0;
        drain();
        cur_ph = dir_tab[i].ph;
        directed_camera(cur_ph);
      end
      send_pixel(dir_tab[i].col, dir_tab[i].row);
      if (dir_tab[i].known && texel_q[$] != dir_tab[i].res) begin
        errors++;
        $display("%0t: table row %0d expected %h predicted %h", $time, i,
                 dir_tab[i].res, texel_q[$]);
      end
    end

    // random scenes
    for (int p = 0; p < RAND_PHASES; p++) begin
      in_valid <= 1'b0;
      drain();
      calm = (p % 3 == 0);
      random_camera();
      for (int k = 0; k < RAND_ITEMS; k++)
        send_pixel(($urandom_range(0, 9) < 8)
                     ? 9'($urandom_range(0, PIXELS_PER_LINE - 1))
                     : 9'($urandom_range(0, 511)),
                   8'($urandom_range(0, 255)));
    end
    in_valid <= 1'b0;
    drain();
    repeat (100) @(posedge clk);
    bad = (errors != 0) || (texel_q.size() != 0);
    if (!bad) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
